// File: rtl/abom_pkg.sv
// Shared constants and types for the ask/bid order matcher.
`timescale 1ns / 1ps
`default_nettype none
package abom_pkg;
	localparam int unsigned PW = 48;
	localparam int unsigned DEF_MAX_ASKS = 16;
	localparam int unsigned DEF_MAX_BIDS = 16;
	localparam int unsigned RESULT_CAP = 32;

	localparam logic [1:0] OP_LOAD_ASK = 2'd0;
	localparam logic [1:0] OP_LOAD_BID = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic KIND_ASK = 1'b0;
	localparam logic KIND_BID = 1'b1;

	// one stored order: own flag, amount, price
	typedef struct packed {
		logic own;
		logic [PW-1:0] amount;
		logic [PW-1:0] price;
	} order_t;

	localparam int unsigned ORDER_W = $bits(order_t);

	// result item
	typedef struct packed {
		logic sale_valid;
		logic [PW-1:0] sale_price;
		logic [PW-1:0] sale_amount;
		logic sale_kind;
		logic sale_own_user;
		logic [1:0] status;
		logic last;
	} result_t;
endpackage
`default_nettype wire

// File: rtl/abom_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module abom_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/abom_cmp_unit.sv
// Shared 48-bit compare/subtract unit used by the sort compare and the match price and amount compares.
`timescale 1ns / 1ps
`default_nettype none
module abom_cmp_unit (
	input wire logic [abom_pkg::PW-1:0] a,
	input wire logic [abom_pkg::PW-1:0] b,
	output logic a_lt_b,
	output logic a_eq_b,
	output logic [abom_pkg::PW-1:0] diff
);
	logic [abom_pkg::PW:0] d;

	assign d = {1'b0, a} - {1'b0, b};
	assign a_lt_b = d[abom_pkg::PW];
	assign a_eq_b = (a == b);
	assign diff = d[abom_pkg::PW-1:0];
endmodule
`default_nettype wire

// File: rtl/ask_bid_order_matcher_top.sv
// Top level of the ask/bid order matcher: stores, sort and match sequencer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  request | in  | valid / ready       | operation, price, amount, own_user
//  result  | out | out_valid/out_ready | sale_valid..sale_own_user, status, last
//
// A load is accepted, written, then its result is presented; ready comes back once
// the result is taken. An unused operation code is accepted and dropped.
// A run first sorts ask and bid index lists with a stable insertion sort
// (each inner step reads the previous entry, then compares), then walks asks
// against bids: each ask is read, then for each ask/bid pair the bid is read and
// prices compared; on a trade the amounts are compared and written back. A sale
// is held in the result register until the next sale is found (it is sent
// first) or the run ends. Order counts, prices and amounts set the run length.
// Reset clears counts and the sequencer; the stores hold garbage until loaded.
// A stalled output simply holds the sequencer in its emit state.
`timescale 1ns / 1ps
`default_nettype none
module ask_bid_order_matcher_top #(
	parameter int unsigned MAX_ASKS = abom_pkg::DEF_MAX_ASKS,
	parameter int unsigned MAX_BIDS = abom_pkg::DEF_MAX_BIDS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	input wire logic [1:0] operation,
	input wire logic [abom_pkg::PW-1:0] price,
	input wire logic [abom_pkg::PW-1:0] amount,
	input wire logic own_user,
	output logic out_valid,
	input wire logic out_ready,
	output logic sale_valid,
	output logic [abom_pkg::PW-1:0] sale_price,
	output logic [abom_pkg::PW-1:0] sale_amount,
	output logic sale_kind,
	output logic sale_own_user,
	output logic [1:0] status,
	output logic last
);
	localparam int unsigned PW = abom_pkg::PW;
	localparam int unsigned OW = abom_pkg::ORDER_W;
	localparam int unsigned AIW = (MAX_ASKS > 1) ? $clog2(MAX_ASKS) : 1;
	localparam int unsigned BIW = (MAX_BIDS > 1) ? $clog2(MAX_BIDS) : 1;
	localparam int unsigned ACW = $clog2(MAX_ASKS + 1);
	localparam int unsigned BCW = $clog2(MAX_BIDS + 1);
	localparam int unsigned NW = $clog2(abom_pkg::RESULT_CAP + 1);

	// sequencer states
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_LOAD   = 5'd1;
	localparam logic [4:0] S_EMIT   = 5'd2;
	localparam logic [4:0] S_SORT_I = 5'd3;  // start outer step of sort
	localparam logic [4:0] S_SORT_V = 5'd4;  // read key v
	localparam logic [4:0] S_SORT_VW = 5'd5;
	localparam logic [4:0] S_SORT_R = 5'd6;  // read idx[j-1]
	localparam logic [4:0] S_SORT_RW = 5'd7;
	localparam logic [4:0] S_SORT_C = 5'd8;  // compare
	localparam logic [4:0] S_M_ASK  = 5'd9;  // read ask
	localparam logic [4:0] S_M_ASKW = 5'd10;
	localparam logic [4:0] S_M_BID  = 5'd11; // read bid
	localparam logic [4:0] S_M_BIDW = 5'd12;
	localparam logic [4:0] S_M_PCMP = 5'd13; // price compare
	localparam logic [4:0] S_M_ACMP = 5'd14; // amount compare, write back
	localparam logic [4:0] S_M_NEXT = 5'd15; // advance bid / ask
	localparam logic [4:0] S_FINAL  = 5'd16;

	logic [4:0] state_q;
	logic side_q; // 0 asks, 1 bids (sort phase)
	logic [ACW-1:0] ask_cnt_q;
	logic [BCW-1:0] bid_cnt_q;

	// index lists (small, each entry read at a signal address -> kept narrow,
	// MAX_ASKS and MAX_BIDS entries, 16 each by default)
	logic [AIW-1:0] aidx_q [MAX_ASKS];
	logic [BIW-1:0] bidx_q [MAX_BIDS];

	logic [5:0] i_q, j_q, a_q, b_q;
	logic [5:0] v_q;
	logic [PW-1:0] key_q;
	logic [NW-1:0] n_q;
	logic close_q;
	abom_pkg::order_t ask_q, bid_q, req_q;
	abom_pkg::result_t res_q;
	logic [1:0] op_q;

	// RAM ports
	logic a_we, b_we;
	logic [AIW-1:0] a_wa, a_ra;
	logic [BIW-1:0] b_wa, b_ra;
	logic [OW-1:0] a_wd, b_wd, a_rd, b_rd;
	abom_pkg::order_t a_rec, b_rec, rd_rec;

	abom_ram #(.WIDTH(OW), .DEPTH(MAX_ASKS)) u_ask_ram (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	abom_ram #(.WIDTH(OW), .DEPTH(MAX_BIDS)) u_bid_ram (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

	assign a_rec = abom_pkg::order_t'(a_rd);
	assign b_rec = abom_pkg::order_t'(b_rd);
	assign rd_rec = side_q ? b_rec : a_rec;

	// shared compare unit operands
	logic [PW-1:0] cu_a, cu_b, cu_diff;
	logic cu_lt, cu_eq;
	abom_cmp_unit u_cmp (.a(cu_a), .b(cu_b), .a_lt_b(cu_lt), .a_eq_b(cu_eq),
		.diff(cu_diff));

	always_comb begin
		cu_a = key_q;
		cu_b = rd_rec.price;
		if (state_q == S_M_PCMP) begin
			cu_a = bid_q.price;
			cu_b = ask_q.price;
		end else if (state_q == S_M_ACMP) begin
			cu_a = bid_q.amount;
			cu_b = ask_q.amount;
		end
	end

	// read address selection; idx[j-1] is held through the wait state so the
	// compare state still sees its data
	logic [5:0] rsel;
	always_comb begin
		rsel = v_q;
		if (state_q inside {S_SORT_R, S_SORT_RW})
			rsel = (side_q ? {{(6-BIW){1'b0}}, bidx_q[BIW'(j_q - 6'd1)]}
			: {{(6-AIW){1'b0}}, aidx_q[AIW'(j_q - 6'd1)]});
		else if (state_q == S_M_ASK) rsel = {{(6-AIW){1'b0}}, aidx_q[AIW'(a_q)]};
		else if (state_q == S_M_BID) rsel = {{(6-BIW){1'b0}}, bidx_q[BIW'(b_q)]};
	end
	assign a_ra = AIW'(rsel);
	assign b_ra = BIW'(rsel);

	// load into a full side is dropped
	logic load_full;
	assign load_full = (op_q == abom_pkg::OP_LOAD_ASK) ? (ask_cnt_q >= ACW'(MAX_ASKS))
		: (bid_cnt_q >= BCW'(MAX_BIDS));

	// a new trade waits while an earlier sale still sits in the result register and the result cap is not reached
	logic hold_emit;
	assign hold_emit = res_q.sale_valid && (n_q < NW'(abom_pkg::RESULT_CAP));

	// write ports: loads and amount write-back
	logic [PW-1:0] new_bid_amt, new_ask_amt;
	logic do_match;
	always_comb begin
		a_we = 1'b0;
		b_we = 1'b0;
		a_wa = AIW'(ask_cnt_q);
		b_wa = BIW'(bid_cnt_q);
		a_wd = OW'(req_q);
		b_wd = OW'(req_q);
		new_bid_amt = '0;
		new_ask_amt = ask_q.amount;
		if (cu_eq) begin
			new_bid_amt = '0;
		end else if (!cu_lt) begin
			new_bid_amt = cu_diff;
		end else begin
			new_bid_amt = '0;
			new_ask_amt = ask_q.amount - bid_q.amount;
		end
		do_match = cu_eq || !cu_lt || (bid_q.amount != '0);
		if (state_q == S_LOAD) begin
			a_we = (op_q == abom_pkg::OP_LOAD_ASK) && !load_full;
			b_we = (op_q == abom_pkg::OP_LOAD_BID) && !load_full;
		end else if (state_q == S_M_ACMP && do_match && !hold_emit) begin
			b_we = 1'b1;
			b_wa = bidx_q[BIW'(b_q)];
			b_wd = OW'({bid_q.own, new_bid_amt, bid_q.price});
			a_we = 1'b1;
			a_wa = aidx_q[AIW'(a_q)];
			a_wd = OW'({ask_q.own, new_ask_amt, ask_q.price});
		end
	end

	assign ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign sale_valid = res_q.sale_valid;
	assign sale_price = res_q.sale_price;
	assign sale_amount = res_q.sale_amount;
	assign sale_kind = res_q.sale_kind;
	assign sale_own_user = res_q.sale_own_user;
	assign status = res_q.status;
	assign last = res_q.last;

	logic [5:0] cnt_side;
	assign cnt_side = side_q ? 6'(bid_cnt_q) : 6'(ask_cnt_q);

	// state to return to once the result has been taken
	logic [4:0] ret_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ask_cnt_q <= '0;
			bid_cnt_q <= '0;
			side_q <= 1'b0;
			n_q <= '0;
			ret_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (valid) begin
						op_q <= operation;
						req_q <= '{own: own_user, amount: amount, price: price};
						if (operation == abom_pkg::OP_LOAD_ASK
								|| operation == abom_pkg::OP_LOAD_BID) begin
							state_q <= S_LOAD;
						end else if (operation == abom_pkg::OP_RUN) begin
							n_q <= '0;
							ret_q <= S_IDLE;
							if (ask_cnt_q == '0 || bid_cnt_q == '0) begin
								res_q <= '{default: '0, status: abom_pkg::ST_EMPTY, last: 1'b1};
								ask_cnt_q <= '0;
								bid_cnt_q <= '0;
								state_q <= S_EMIT;
							end else begin
								res_q.sale_valid <= 1'b0;
								side_q <= 1'b0;
								i_q <= 6'd0;
								state_q <= S_SORT_I;
							end
						end
					end
				end
				S_LOAD: begin
					res_q <= '{default: '0,
						status: load_full ? abom_pkg::ST_FULL : abom_pkg::ST_OK, last: 1'b1};
					ret_q <= S_IDLE;
					if (!load_full) begin
						if (op_q == abom_pkg::OP_LOAD_ASK) ask_cnt_q <= ask_cnt_q + ACW'(1);
						else bid_cnt_q <= bid_cnt_q + BCW'(1);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) state_q <= ret_q;
				end
				S_SORT_I: begin
					if (i_q == cnt_side) begin
						if (!side_q) begin
							side_q <= 1'b1;
							i_q <= 6'd0;
						end else begin
							a_q <= 6'd0;
							state_q <= S_M_ASK;
						end
					end else begin
						v_q <= i_q;
						j_q <= i_q;
						state_q <= S_SORT_V;
					end
				end
				S_SORT_V: state_q <= S_SORT_VW;
				S_SORT_VW: begin
					key_q <= rd_rec.price;
					state_q <= (j_q == 6'd0) ? S_SORT_C : S_SORT_R;
				end
				S_SORT_R: state_q <= S_SORT_RW;
				S_SORT_RW: state_q <= S_SORT_C;
				S_SORT_C: begin
					// move when prev > key (asks) or prev < key (bids)
					if (j_q != 6'd0 && (side_q ? (!cu_lt && !cu_eq) : cu_lt)) begin
						if (side_q) bidx_q[BIW'(j_q)] <= bidx_q[BIW'(j_q - 6'd1)];
						else aidx_q[AIW'(j_q)] <= aidx_q[AIW'(j_q - 6'd1)];
						j_q <= j_q - 6'd1;
						state_q <= (j_q == 6'd1) ? S_SORT_C : S_SORT_R;
					end else begin
						if (side_q) bidx_q[BIW'(j_q)] <= BIW'(v_q);
						else aidx_q[AIW'(j_q)] <= AIW'(v_q);
						i_q <= i_q + 6'd1;
						state_q <= S_SORT_I;
					end
				end
				S_M_ASK: state_q <= S_M_ASKW;
				S_M_ASKW: begin
					ask_q <= a_rec;
					b_q <= 6'd0;
					state_q <= S_M_BID;
				end
				S_M_BID: state_q <= S_M_BIDW;
				S_M_BIDW: begin
					bid_q <= b_rec;
					state_q <= S_M_PCMP;
				end
				S_M_PCMP: begin
					// cu: bid.price < ask.price -> skip
					state_q <= cu_lt ? S_M_NEXT : S_M_ACMP;
					close_q <= 1'b0;
				end
				S_M_ACMP: begin
					close_q <= cu_eq || !cu_lt;
					if (do_match && hold_emit) begin
						// send the earlier sale, then redo this compare
						ret_q <= S_M_ACMP;
						state_q <= S_EMIT;
					end else if (do_match) begin
						ask_q.amount <= new_ask_amt;
						if (n_q < NW'(abom_pkg::RESULT_CAP)) begin
							res_q.sale_valid <= 1'b1;
							res_q.sale_price <= ask_q.price;
							res_q.sale_amount <= (cu_eq || !cu_lt) ? ask_q.amount : bid_q.amount;
							res_q.sale_kind <= ask_q.own ? abom_pkg::KIND_ASK
								: (bid_q.own ? abom_pkg::KIND_BID : abom_pkg::KIND_ASK);
							res_q.sale_own_user <= ask_q.own | bid_q.own;
							res_q.status <= abom_pkg::ST_OK;
							res_q.last <= 1'b0;
							n_q <= n_q + NW'(1);
						end
						state_q <= S_M_NEXT;
					end else begin
						state_q <= S_M_NEXT;
					end
				end
				S_M_NEXT: begin
					if (!close_q && (b_q + 6'd1) < 6'(bid_cnt_q)) begin
						b_q <= b_q + 6'd1;
						state_q <= S_M_BID;
					end else if ((a_q + 6'd1) < 6'(ask_cnt_q)) begin
						a_q <= a_q + 6'd1;
						state_q <= S_M_ASK;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					// the held sale, if any, is the last one of the run
					ask_cnt_q <= '0;
					bid_cnt_q <= '0;
					ret_q <= S_IDLE;
					if (n_q == '0) begin
						res_q <= '{default: '0, status: abom_pkg::ST_OK, last: 1'b1};
					end else begin
						res_q.last <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
			// after an intermediate sale leaves, mark it consumed
			if (state_q == S_EMIT && out_ready && ret_q != S_IDLE) begin
				res_q.sale_valid <= 1'b0;
				if (res_q.last) res_q.last <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
